### sv/wsfr_pkg.sv
`default_nettype none

package wsfr_pkg;

    // frame kinds
    localparam logic [1:0] KIND_IGNORE  = 2'd0;
    localparam logic [1:0] KIND_MESSAGE = 2'd1;
    localparam logic [1:0] KIND_PONG    = 2'd2;

    // opcodes
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [6:0] MAX_SMALL_LEN = 7'd125;
    localparam logic [7:0] FIN_BIT       = 8'h80;
    localparam logic [7:0] PONG_HDR_BYTE = FIN_BIT | {4'h0, OP_PONG};

    localparam int QUEUE_DEPTH = 2;

    // one queue entry: one result, or a pong header pair when two is set
    // (first result of a pair is always the fixed pong header byte)
    typedef struct packed {
        logic       dest;
        logic       two;
        logic [7:0] data;
        logic       empty;
        logic       trunc;
        logic       last;
    } res_entry_t;

endpackage

`default_nettype wire

### sv/websocket_small_frame_receiver.sv
// websocket small-frame receiver
// input channel: one received byte per transaction (rx_byte, segment_end),
//   handshake in_valid / in_stall; one frame is expected at the start of
//   each segment and segment_end marks the segment's last byte
// output channel: one result per transaction (dest, out_byte, empty_res,
//   truncated, last), handshake out_valid / out_stall; dest 0 is unmasked
//   text/binary payload for the application, dest 1 is a pong frame to send
// cfg_wr_en / cfg_wr_data write link_open; bytes give no results while it is 0
// throughput: one byte per cycle while in_stall is low; a ping length byte
//   yields two results (pong header plus length), sent one after the other
// path: combinational decode writes the two-entry queue, and the output
//   register loads from the queue head
// stall: out_stall holds the output register; the queue absorbs up to two
//   pending results, after that in_stall rises until the back end drains
// reset: link closed, segment position and frame state cleared, queue and
//   output register empty
`default_nettype none

module websocket_small_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       segment_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            dest,
    output logic [7:0]      out_byte,
    output logic            empty_res,
    output logic            truncated,
    output logic            last
);

    logic                 fire;
    logic                 push;
    wsfr_pkg::res_entry_t push_entry;
    logic                 pop;
    logic                 full;
    logic                 head_valid;
    wsfr_pkg::res_entry_t head_entry;

    // input transaction whenever the queue has room
    assign in_stall = full;
    assign fire     = in_valid && !full;

    // front: byte position, header decode, key capture, unmasking
    wsfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .rx_byte     (rx_byte),
        .segment_end (segment_end),
        .push        (push),
        .push_entry  (push_entry)
    );

    // decouples decode from output back-pressure
    wsfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back: expands pong pairs and drives the output register
    wsfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .dest       (dest),
        .out_byte   (out_byte),
        .empty_res  (empty_res),
        .truncated  (truncated),
        .last       (last)
    );

    // a truncated result always closes its message
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> last)
        else $error("truncated result without last");

endmodule

`default_nettype wire

### sv/wsfr_front.sv
`default_nettype none

module wsfr_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic                 fire,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 segment_end,
    output logic                      push,
    output wsfr_pkg::res_entry_t      push_entry
);

    logic       link_open_reg;
    logic [7:0] pos_reg, pos_next;
    logic [1:0] kind_reg, kind_next;
    logic       mask_reg, mask_next;
    logic [6:0] len_reg, len_next;
    logic       done_reg, done_next;
    logic [7:0] key_reg [4];
    logic [7:0] key_next [4];

    logic                 has_res;
    wsfr_pkg::res_entry_t ent;
    logic [7:0]           start;
    logic [7:0]           idx;
    logic                 fin;

    always_comb
    begin
        pos_next  = pos_reg;
        kind_next = kind_reg;
        mask_next = mask_reg;
        len_next  = len_reg;
        done_next = done_reg;
        key_next  = key_reg;
        has_res   = 1'b0;
        ent       = '0;
        start     = mask_reg ? 8'd6 : 8'd2;
        idx       = pos_reg - start;
        fin       = 1'b0;

        if (!link_open_reg)
        begin
            kind_next = wsfr_pkg::KIND_IGNORE;
        end
        else if (!done_reg)
        begin
            if (pos_reg == 8'd0)
            begin
                case (rx_byte[3:0])
                    wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BINARY:
                        kind_next = wsfr_pkg::KIND_MESSAGE;
                    wsfr_pkg::OP_PING:
                        kind_next = wsfr_pkg::KIND_PONG;
                    default:
                        kind_next = wsfr_pkg::KIND_IGNORE;
                endcase
            end
            else if (kind_reg != wsfr_pkg::KIND_IGNORE)
            begin
                if (pos_reg == 8'd1)
                begin
                    mask_next = rx_byte[7];
                    len_next  = rx_byte[6:0];
                    if (rx_byte[6:0] > wsfr_pkg::MAX_SMALL_LEN)
                    begin
                        kind_next = wsfr_pkg::KIND_IGNORE;
                    end
                    else
                    begin
                        if (kind_reg == wsfr_pkg::KIND_PONG)
                        begin
                            has_res  = 1'b1;
                            ent.two  = 1'b1;
                            ent.data = {1'b0, rx_byte[6:0]};
                            ent.last = (rx_byte[6:0] == 7'd0);
                        end
                        else if (rx_byte[6:0] == 7'd0)
                        begin
                            has_res   = 1'b1;
                            ent.empty = 1'b1;
                            ent.last  = 1'b1;
                        end
                        if (rx_byte[6:0] == 7'd0)
                            done_next = 1'b1;
                    end
                end
                else if (mask_reg && pos_reg <= 8'd5)
                begin
                    // key byte index is (pos - 2) mod 4
                    key_next[pos_reg[1:0] ^ 2'b10] = rx_byte;
                end
                else if (pos_reg >= start && idx < {1'b0, len_reg})
                begin
                    fin      = ((idx + 8'd1) == {1'b0, len_reg});
                    has_res  = 1'b1;
                    ent.data = mask_reg ? (rx_byte ^ key_reg[idx[1:0]]) : rx_byte;
                    ent.last = fin;
                    if (fin)
                        done_next = 1'b1;
                end
            end
        end

        // routing follows the frame kind before the segment end clears it
        ent.dest = (kind_next == wsfr_pkg::KIND_PONG) || ent.two;

        // segment end closes any frame still open
        if (segment_end)
        begin
            if (link_open_reg && kind_next != wsfr_pkg::KIND_IGNORE && !done_next)
            begin
                if (!has_res)
                begin
                    has_res   = 1'b1;
                    ent.empty = 1'b1;
                    ent.data  = 8'd0;
                end
                ent.trunc = 1'b1;
                ent.last  = 1'b1;
            end
            pos_next  = 8'd0;
            kind_next = wsfr_pkg::KIND_IGNORE;
            mask_next = 1'b0;
            len_next  = 7'd0;
            done_next = 1'b0;
        end
        else
        begin
            pos_next = (pos_reg == 8'hFF) ? pos_reg : pos_reg + 8'd1;
        end
    end

    assign push       = fire && has_res;
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_open_reg <= 1'b0;
            pos_reg       <= 8'd0;
            kind_reg      <= wsfr_pkg::KIND_IGNORE;
            mask_reg      <= 1'b0;
            len_reg       <= 7'd0;
            done_reg      <= 1'b0;
            for (int k = 0; k < 4; k++)
                key_reg[k] <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
                link_open_reg <= cfg_wr_data;
            if (fire)
            begin
                pos_reg  <= pos_next;
                kind_reg <= kind_next;
                mask_reg <= mask_next;
                len_reg  <= len_next;
                done_reg <= done_next;
                key_reg  <= key_next;
            end
        end
    end

    // an empty result is always a message end with no data
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.empty |-> push_entry.last && push_entry.data == 8'd0)
        else $error("empty result without last");

    // a pong pair only comes from the length byte of a ping
    a_two_pong: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.two |-> pos_reg == 8'd1 && kind_reg == wsfr_pkg::KIND_PONG)
        else $error("pong pair outside length byte");

endmodule

`default_nettype wire

### sv/wsfr_queue.sv
`default_nettype none

module wsfr_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire wsfr_pkg::res_entry_t push_entry,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      head_valid,
    output wsfr_pkg::res_entry_t      head_entry
);

    localparam int PTR_W = (wsfr_pkg::QUEUE_DEPTH > 1) ? $clog2(wsfr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(wsfr_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(wsfr_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(wsfr_pkg::QUEUE_DEPTH - 1);

    wsfr_pkg::res_entry_t entries_reg [wsfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
            count_next = count_reg + 1'b1;
        else if (!push && pop && head_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && head_valid)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count out of range");

endmodule

`default_nettype wire

### sv/wsfr_back.sv
`default_nettype none

module wsfr_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire wsfr_pkg::res_entry_t head_entry,
    output logic                      pop,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic                      dest,
    output logic [7:0]                out_byte,
    output logic                      empty_res,
    output logic                      truncated,
    output logic                      last
);

    logic       valid_reg;
    logic       phase_reg;
    logic       dest_reg;
    logic [7:0] byte_reg;
    logic       empty_reg;
    logic       trunc_reg;
    logic       last_reg;
    logic       load;
    logic       hdr;

    assign load = head_valid && (!valid_reg || !out_stall);
    // first half of a pong pair goes out as the fixed header byte
    assign hdr  = head_entry.two && !phase_reg;
    assign pop  = load && !hdr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= hdr;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dest_reg  <= head_entry.dest;
            byte_reg  <= hdr ? wsfr_pkg::PONG_HDR_BYTE : head_entry.data;
            empty_reg <= hdr ? 1'b0 : head_entry.empty;
            trunc_reg <= hdr ? 1'b0 : head_entry.trunc;
            last_reg  <= hdr ? 1'b0 : head_entry.last;
        end
    end

    assign out_valid = valid_reg;
    assign dest      = dest_reg;
    assign out_byte  = byte_reg;
    assign empty_res = empty_reg;
    assign truncated = trunc_reg;
    assign last      = last_reg;

    // while the pair is half sent the header byte sits in the output register
    a_phase_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> valid_reg && byte_reg == wsfr_pkg::PONG_HDR_BYTE && dest_reg)
        else $error("pong header not held");

endmodule

`default_nettype wire
